// ----- rtl/core/msam_pkg.sv -----
// Shared types, constants and helpers for the multi-source audio mixer.
package msam_pkg;

    localparam int PCM_W           = 16;
    localparam int VOL_W           = 7;
    localparam int SRC_SLOTS       = 4;
    localparam int NUM_SOURCES_DEF = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 7;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_VOL0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO = 3'd4;

    localparam logic [VOL_W-1:0] FULL_GAIN = 7'd100;

    // Scaled product: 16-bit sample times an 8-bit signed view of the volume.
    localparam int PROD_W = PCM_W + VOL_W + 1;
    // Largest product magnitude is 32768 * 99, which fits in 22 bits.
    localparam int MAG_W  = 22;

    // Division by 100 as a multiply by ceil(2^29 / 100). The rounding error
    // of the constant times the largest magnitude stays below 2^29, so the
    // quotient is exact over the whole 22-bit range.
    localparam int                RECIP_SHIFT = 29;
    localparam int                RECIP_W     = 23;
    localparam logic [RECIP_W-1:0] RECIP_K    = 23'd5368710;
    localparam int                QUOT_W      = MAG_W + RECIP_W;

    localparam logic signed [PCM_W:0] PCM_MAX = 17'sd32767;
    localparam logic signed [PCM_W:0] PCM_MIN = -17'sd32768;

    typedef logic signed [PCM_W-1:0] pcm_t;

    typedef struct packed {
        logic             stereo;
        logic [VOL_W-1:0] volume;
    } lane_cfg_t;

    // Adds one scaled source to the running mix and clamps to 16 bits.
    function automatic pcm_t sat_add(input pcm_t acc, input pcm_t x);
        logic signed [PCM_W:0] sum;
        sum = {acc[PCM_W-1], acc} + {x[PCM_W-1], x};
        if (sum > PCM_MAX)
            return PCM_MAX[PCM_W-1:0];
        else if (sum < PCM_MIN)
            return PCM_MIN[PCM_W-1:0];
        else
            return sum[PCM_W-1:0];
    endfunction

endpackage

// ----- rtl/core/msam_lane.sv -----
// One source lane: stereo downmix, volume multiply, then exact divide by 100.
module msam_lane (
    input  logic               clk,
    input  msam_pkg::lane_cfg_t cfg,
    input  logic               present,
    input  msam_pkg::pcm_t     left,
    input  msam_pkg::pcm_t     right,
    output msam_pkg::pcm_t     scaled
);
    import msam_pkg::*;

    logic signed [PCM_W:0]    pair_sum;
    logic signed [PCM_W:0]    pair_half;
    pcm_t                     mono;
    logic signed [VOL_W:0]    vol_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] a_val_next;
    logic                     a_unity_next;

    logic signed [PROD_W-1:0] a_val_reg;
    logic                     a_unity_reg;
    logic                     a_present_reg;

    logic                     neg;
    logic [PROD_W-1:0]        abs_val;
    logic [MAG_W-1:0]         mag;
    logic [QUOT_W-1:0]        quot_full;
    pcm_t                     quot;
    pcm_t                     b_out_next;
    pcm_t                     b_out_reg;

    // Stage A: average to mono (truncating toward zero) and multiply.
    always_comb
    begin
        pair_sum  = {left[PCM_W-1], left} + {right[PCM_W-1], right};
        pair_half = (pair_sum + {{PCM_W{1'b0}}, pair_sum[PCM_W]}) >>> 1;
        mono      = cfg.stereo ? pair_half[PCM_W-1:0] : left;
        vol_s     = {1'b0, cfg.volume};
        prod      = mono * vol_s;
        // A volume of 100 or more passes the sample through untouched.
        a_unity_next = (cfg.volume >= FULL_GAIN);
        a_val_next   = a_unity_next ? PROD_W'(mono) : prod;
    end

    always_ff @(posedge clk)
    begin
        a_val_reg     <= a_val_next;
        a_unity_reg   <= a_unity_next;
        a_present_reg <= present;
    end

    // Stage B: divide the magnitude by 100 with a reciprocal multiply.
    always_comb
    begin
        neg       = a_val_reg[PROD_W-1];
        abs_val   = neg ? PROD_W'(-a_val_reg) : PROD_W'(a_val_reg);
        mag       = abs_val[MAG_W-1:0];
        quot_full = QUOT_W'(mag) * QUOT_W'(RECIP_K);
        quot      = quot_full[RECIP_SHIFT +: PCM_W];
        if (!a_present_reg)
            b_out_next = '0;
        else if (a_unity_reg)
            b_out_next = a_val_reg[PCM_W-1:0];
        else
            b_out_next = neg ? -quot : quot;
    end

    always_ff @(posedge clk)
    begin
        b_out_reg <= b_out_next;
    end

    assign scaled = b_out_reg;

endmodule

// ----- rtl/core/msam_sum.sv -----
// Saturating mix of the scaled lanes in source order, with the result register.
module msam_sum #(
    parameter int NUM_SOURCES = msam_pkg::NUM_SOURCES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  msam_pkg::pcm_t lane_val [NUM_SOURCES],
    output logic           out_valid,
    output msam_pkg::pcm_t mix
);
    import msam_pkg::*;

    pcm_t acc [NUM_SOURCES+1];
    pcm_t mix_next;
    pcm_t mix_reg;
    logic valid_reg;

    // The clamp is applied after every add, so the order of sources matters.
    always_comb
    begin
        acc[0] = '0;
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            acc[i+1] = sat_add(acc[i], lane_val[i]);
        end
        mix_next = acc[NUM_SOURCES];
    end

    always_ff @(posedge clk)
    begin
        mix_reg <= mix_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    assign out_valid = valid_reg;
    assign mix       = mix_reg;

endmodule

// ----- rtl/core/multi_source_audio_mixer.sv -----
// Top level of the four-input saturating PCM audio mixer.
// A request is held in the input, multiply, divide and mix registers in turn before its
// mix is shown on the outputs. Throughput: one request per cycle; busy stays low.
// Reset clears the pipeline valid bits, sets all volumes to 100 and every
// source to stereo. Results cannot be stalled by the receiver.
module multi_source_audio_mixer #(
    parameter int NUM_SOURCES = msam_pkg::NUM_SOURCES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cfg_write,
    input  logic [msam_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [msam_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [msam_pkg::SRC_SLOTS-1:0]      present_mask,
    input  msam_pkg::pcm_t                      src0_left,
    input  msam_pkg::pcm_t                      src0_right,
    input  msam_pkg::pcm_t                      src1_left,
    input  msam_pkg::pcm_t                      src1_right,
    input  msam_pkg::pcm_t                      src2_left,
    input  msam_pkg::pcm_t                      src2_right,
    input  msam_pkg::pcm_t                      src3_left,
    input  msam_pkg::pcm_t                      src3_right,
    output logic                                result_valid,
    output msam_pkg::pcm_t                      mix_left,
    output msam_pkg::pcm_t                      mix_right
);
    import msam_pkg::*;

    logic [VOL_W-1:0]       volume_reg [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] stereo_reg;

    pcm_t                   samp_left  [SRC_SLOTS];
    pcm_t                   samp_right [SRC_SLOTS];

    logic                   accept;
    logic [NUM_SOURCES-1:0] in_present_reg;
    pcm_t                   in_left_reg  [NUM_SOURCES];
    pcm_t                   in_right_reg [NUM_SOURCES];
    logic                   v0_reg;
    logic                   v1_reg;
    logic                   v2_reg;

    lane_cfg_t              lane_cfg [NUM_SOURCES];
    pcm_t                   lane_val [NUM_SOURCES];
    pcm_t                   mix;

    // The datapath is fully pipelined, so a request is taken every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign samp_left[0]  = src0_left;
    assign samp_left[1]  = src1_left;
    assign samp_left[2]  = src2_left;
    assign samp_left[3]  = src3_left;
    assign samp_right[0] = src0_right;
    assign samp_right[1] = src1_right;
    assign samp_right[2] = src2_right;
    assign samp_right[3] = src3_right;

    // Writes to volume slots beyond the built lanes have no visible effect.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                volume_reg[i] <= FULL_GAIN;
            end
            stereo_reg <= '1;
        end
        else if (cfg_write)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                if (cfg_index == CFG_IDX_W'(REG_VOL0 + CFG_IDX_W'(i)))
                    volume_reg[i] <= cfg_data[VOL_W-1:0];
            end
            if (cfg_index == REG_STEREO)
                stereo_reg <= cfg_data[NUM_SOURCES-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_present_reg <= present_mask[NUM_SOURCES-1:0];
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                in_left_reg[i]  <= samp_left[i];
                in_right_reg[i] <= samp_right[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    for (genvar g = 0; g < NUM_SOURCES; g++)
    begin : g_lane
        assign lane_cfg[g].stereo = stereo_reg[g];
        assign lane_cfg[g].volume = volume_reg[g];

        msam_lane u_lane (
            .clk     (clk),
            .cfg     (lane_cfg[g]),
            .present (in_present_reg[g]),
            .left    (in_left_reg[g]),
            .right   (in_right_reg[g]),
            .scaled  (lane_val[g])
        );
    end

    msam_sum #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .lane_val  (lane_val),
        .out_valid (result_valid),
        .mix       (mix)
    );

    assign mix_left  = mix;
    assign mix_right = mix;

endmodule

// ----- rtl/core/msam_check.sv -----
// Port-level timing and value checks for the mixer, bound to the top level.
module msam_check (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic [msam_pkg::SRC_SLOTS-1:0]  present_mask,
    input logic                            result_valid,
    input msam_pkg::pcm_t                  mix_left,
    input msam_pkg::pcm_t                  mix_right
);
    import msam_pkg::*;

    // Every request is followed by a result strobe.
    a_result_follows: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 result_valid
    ) else $error("request did not produce a result after four cycles");

    // No result shows up without a matching earlier request.
    a_no_spurious: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, 4)
    ) else $error("result strobe without a matching request");

    // Both output channels carry the same mono mix.
    a_channels_equal: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> (mix_left == mix_right)
    ) else $error("left and right mix differ");

    // A frame with no source present mixes to silence.
    a_silent_frame: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy && (present_mask == '0)) |-> ##4 (mix_left == '0)
    ) else $error("empty frame produced a nonzero mix");

endmodule

bind multi_source_audio_mixer msam_check u_msam_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .present_mask (present_mask),
    .result_valid (result_valid),
    .mix_left     (mix_left),
    .mix_right    (mix_right)
);

// ----- test/tb_multi_source_audio_mixer.sv -----
// Self-checking testbench for the four-source saturating PCM audio mixer.
module tb_multi_source_audio_mixer;

    timeunit 1ns;
    timeprecision 1ps;

    import msam_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int RESET_TICKS = 6;
    localparam int PIPE_DEPTH  = 5;
    localparam int SETTLE      = 2 * PIPE_DEPTH;
    localparam int IDLE_LIMIT  = 2000;
    localparam int N_SRC       = NUM_SOURCES_DEF;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 100;
    localparam logic [CFG_IDX_W-1:0] REG_TOP = CFG_IDX_W'((1 << CFG_IDX_W) - 1);
    localparam pcm_t PCM_HI = PCM_MAX[PCM_W-1:0];
    localparam pcm_t PCM_LO = PCM_MIN[PCM_W-1:0];

    typedef struct {
        logic [SRC_SLOTS-1:0] present;
        pcm_t                 left  [SRC_SLOTS];
        pcm_t                 right [SRC_SLOTS];
    } frame_t;

    class mix_scoreboard;
        logic [VOL_W-1:0]     volume [SRC_SLOTS];
        logic [SRC_SLOTS-1:0] stereo;
        pcm_t                 expected_mix [$];
        int                   failures;
        int                   frames;
        int                   mixes;

        function new();
            foreach (volume[i])
                volume[i] = FULL_GAIN;
            stereo = '1;
        endfunction

        // Writes to indexes past the stereo mask are dropped.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (int'(idx) < int'(REG_VOL0) + SRC_SLOTS)
                volume[idx - REG_VOL0] = data[VOL_W-1:0];
            else if (idx == REG_STEREO)
                stereo = data[SRC_SLOTS-1:0];
        endfunction

        function pcm_t mix_frame(frame_t f);
            int acc;
            int s;
            acc = 0;
            for (int i = 0; i < N_SRC && i < SRC_SLOTS; i++) begin
                if (f.present[i]) begin
                    // SystemVerilog integer division truncates toward zero.
                    s = stereo[i] ? (int'(f.left[i]) + int'(f.right[i])) / 2 : int'(f.left[i]);
                    if (volume[i] < FULL_GAIN)
                        s = (s * int'(volume[i])) / int'(FULL_GAIN);
                    acc = acc + s;
                    if (acc > PCM_MAX)
                        acc = PCM_MAX;
                    else if (acc < PCM_MIN)
                        acc = PCM_MIN;
                end
            end
            return acc[PCM_W-1:0];
        endfunction

        function void note_frame(frame_t f);
            expected_mix.push_back(mix_frame(f));
            frames++;
        endfunction

        function void check_mix(pcm_t got_left, pcm_t got_right);
            pcm_t want;
            mixes++;
            if (expected_mix.size() == 0) begin
                $error("mix result with no request outstanding: left %0d right %0d",
                       got_left, got_right);
                failures++;
                return;
            end
            want = expected_mix.pop_front();
            if (got_left !== want) begin
                $error("mix_left: expected %0d, got %0d", want, got_left);
                failures++;
            end
            if (got_right !== want) begin
                $error("mix_right: expected %0d, got %0d", want, got_right);
                failures++;
            end
        endfunction

        function int pending();
            return expected_mix.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic [SRC_SLOTS-1:0]  present_mask;
    pcm_t                  src0_left, src0_right, src1_left, src1_right;
    pcm_t                  src2_left, src2_right, src3_left, src3_right;
    logic                  result_valid;
    pcm_t                  mix_left;
    pcm_t                  mix_right;

    mix_scoreboard sb = new();
    int            idle_cycles;
    int            cfg_writes;
    int            settings;
    bit            burst_mode;
    frame_t        req_seen;

    multi_source_audio_mixer #(
        .NUM_SOURCES (N_SRC)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .present_mask (present_mask),
        .src0_left    (src0_left),
        .src0_right   (src0_right),
        .src1_left    (src1_left),
        .src1_right   (src1_right),
        .src2_left    (src2_left),
        .src2_right   (src2_right),
        .src3_left    (src3_left),
        .src3_right   (src3_right),
        .result_valid (result_valid),
        .mix_left     (mix_left),
        .mix_right    (mix_right)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Requests, results and register writes are all observed at the edge that takes them.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
            begin
                sb.write_reg(cfg_index, cfg_data);
                cfg_writes++;
            end
            if (start && !busy)
            begin
                req_seen.present  = present_mask;
                req_seen.left[0]  = src0_left;
                req_seen.right[0] = src0_right;
                req_seen.left[1]  = src1_left;
                req_seen.right[1] = src1_right;
                req_seen.left[2]  = src2_left;
                req_seen.right[2] = src2_right;
                req_seen.left[3]  = src3_left;
                req_seen.right[3] = src3_right;
                sb.note_frame(req_seen);
            end
            if (result_valid)
                sb.check_mix(mix_left, mix_right);
            if ((start && !busy) || result_valid)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Timed out after %0d cycles without a request or a result.", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic frame_t uniform_frame(logic [SRC_SLOTS-1:0] present, pcm_t l, pcm_t r);
        frame_t f;
        f.present = present;
        foreach (f.left[i])
        begin
            f.left[i]  = l;
            f.right[i] = r;
        end
        return f;
    endfunction

    function automatic pcm_t pick_sample();
        int roll;
        roll = $urandom_range(0, 99);
        case (roll % 5)
            0: return (roll < 15) ? PCM_HI : pcm_t'($urandom_range(0, 65535));
            1: return (roll < 15) ? PCM_LO : pcm_t'($urandom_range(0, 65535));
            2: return (roll < 15) ? pcm_t'(-1) : pcm_t'($urandom_range(0, 65535));
            default: return (roll < 10) ? pcm_t'($urandom_range(0, 3)) :
                                          pcm_t'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_volume();
        int roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0: return '0;
            1: return 7'd1;
            2: return CFG_DATA_W'(FULL_GAIN - 1);
            3: return FULL_GAIN;
            4: return '1;
            default: return CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
        endcase
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        f.present = ($urandom_range(0, 1) == 0) ? '1 :
                    SRC_SLOTS'($urandom_range(0, (1 << SRC_SLOTS) - 1));
        foreach (f.left[i])
        begin
            f.left[i]  = pick_sample();
            f.right[i] = pick_sample();
        end
        return f;
    endfunction

    // Entered at a clock edge; returns once the register write is taken and the strobe is low again.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic pause_sender();
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        if (burst_mode || roll < 55)
            gap = 0;
        else if (roll < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Start stays high into the next request when no gap is drawn.
    task automatic send_frame(frame_t f);
        present_mask <= f.present;
        src0_left    <= f.left[0];
        src0_right   <= f.right[0];
        src1_left    <= f.left[1];
        src1_right   <= f.right[1];
        src2_left    <= f.left[2];
        src2_right   <= f.right[2];
        src3_left    <= f.left[3];
        src3_right   <= f.right[3];
        start        <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pause_sender();
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_volumes(logic [CFG_DATA_W-1:0] v0, logic [CFG_DATA_W-1:0] v1,
                               logic [CFG_DATA_W-1:0] v2, logic [CFG_DATA_W-1:0] v3,
                               logic [CFG_DATA_W-1:0] stereo_bits);
        write_reg(REG_VOL0,                    v0);
        write_reg(CFG_IDX_W'(REG_VOL0 + 1),    v1);
        write_reg(CFG_IDX_W'(REG_VOL0 + 2),    v2);
        write_reg(CFG_IDX_W'(REG_VOL0 + 3),    v3);
        write_reg(REG_STEREO,                  stereo_bits);
        settings++;
    endtask

    initial
    begin
        frame_t f;
        int     pause_at;

        rst_n        <= 1'b0;
        start        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        present_mask <= '0;
        src0_left    <= '0;
        src0_right   <= '0;
        src1_left    <= '0;
        src1_right   <= '0;
        src2_left    <= '0;
        src2_right   <= '0;
        src3_left    <= '0;
        src3_right   <= '0;
        burst_mode   = 1'b1;
        settings     = 1;
        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: full volume, every source stereo.
        send_frame(uniform_frame('0, PCM_HI, PCM_HI));
        send_frame(uniform_frame('1, PCM_HI, PCM_HI));
        send_frame(uniform_frame('1, PCM_LO, PCM_LO));
        send_frame(uniform_frame(4'b0001, 16'sd1, 16'sd0));
        send_frame(uniform_frame(4'b0001, -16'sd1, 16'sd0));
        send_frame(uniform_frame('1, -16'sd3, 16'sd0));
        // Positive clamp after two sources, then the third pulls the mix back down.
        f = uniform_frame(4'b0111, PCM_HI, PCM_HI);
        f.left[2]  = PCM_LO;
        f.right[2] = PCM_LO;
        send_frame(f);
        for (int i = 0; i < SRC_SLOTS; i++)
            send_frame(uniform_frame(4'b0001 << i, pcm_t'(1000 * (i + 1)), pcm_t'(-77 * i)));
        drain();

        // Volume extremes; the stereo write carries bits above the mask width.
        set_volumes('0, 7'd1, CFG_DATA_W'(FULL_GAIN - 1), CFG_DATA_W'(FULL_GAIN + 1), 7'h7A);
        for (int idx = REG_STEREO + 1; idx <= REG_TOP; idx++)
            write_reg(CFG_IDX_W'(idx), '0);
        send_frame(uniform_frame('1, PCM_LO, PCM_HI));
        send_frame(uniform_frame('1, PCM_HI, PCM_LO));
        send_frame(uniform_frame('1, PCM_LO, PCM_LO));
        send_frame(uniform_frame('1, 16'sd150, 16'sd50));
        send_frame(uniform_frame('1, -16'sd150, -16'sd51));
        send_frame(uniform_frame(4'b1000, 16'sd12345, -16'sd1));
        drain();

        set_volumes(FULL_GAIN, FULL_GAIN, FULL_GAIN, '1, '0);
        send_frame(uniform_frame('1, 16'sd20000, -16'sd20000));
        send_frame(uniform_frame('1, -16'sd20000, 16'sd20000));
        drain();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if (p == 0)
                set_volumes('0, '0, '0, '0, '0);
            else if (p == 1)
                set_volumes('1, '1, '1, '1, '1);
            else
                set_volumes(pick_volume(), pick_volume(), pick_volume(), pick_volume(),
                            CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_STEREO + 1, REG_TOP)),
                          CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
            pause_at = $urandom_range(20, PHASE_ITEMS - 20);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 25 == 0)
                    burst_mode = ($urandom_range(0, 2) == 0);
                // Hold off until the pipeline has emptied, then carry on.
                if (n == pause_at)
                    drain();
                send_frame(random_frame());
            end
            drain();
        end

        $display("Mixed %0d frames and checked %0d results over %0d register settings.",
                 sb.frames, sb.mixes, settings);
        $display("Register writes: %0d, including writes past the last register.", cfg_writes);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- multi_source_audio_mixer.f -----
rtl/core/msam_pkg.sv
rtl/core/msam_lane.sv
rtl/core/msam_sum.sv
rtl/core/multi_source_audio_mixer.sv
rtl/core/msam_check.sv
test/tb_multi_source_audio_mixer.sv
